[design/fci_pkg.sv]
package fci_pkg;

  localparam int TEMP_W         = 8;
  localparam int SPEED_W        = 8;
  localparam int PCT_W          = 7;
  localparam int COUNT_W        = 4;
  localparam int CFG_IDX_W      = 3;
  localparam int CFG_DATA_W     = 32;
  localparam int HW_POINTS      = 8;
  localparam int PT_IDX_W       = 3;
  localparam int PAIRS          = 4;
  localparam int MAX_POINTS_DEF = 8;

  localparam int DIFF_W = TEMP_W + 1;
  localparam int P1_W   = SPEED_W + DIFF_W;
  localparam int P2_W   = 2 * DIFF_W;
  localparam int NUM_W  = P2_W + 1;
  localparam int DVD_W  = NUM_W;
  localparam int DVS_W  = TEMP_W + 1;

  localparam logic [PCT_W-1:0] DEFAULT_PCT = PCT_W'(50);
  localparam logic [PCT_W-1:0] MAX_PCT     = PCT_W'(100);
  localparam logic [PCT_W-1:0] MIN_PCT     = PCT_W'(0);

  localparam logic [CFG_IDX_W-1:0] CFG_POINT_COUNT = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_POINTS_0_1  = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_POINTS_2_3  = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_POINTS_4_5  = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] CFG_POINTS_6_7  = CFG_IDX_W'(4);

  typedef struct packed {
    logic signed [TEMP_W-1:0]  t_min;
    logic signed [SPEED_W-1:0] s_min;
    logic signed [TEMP_W-1:0]  t_max;
    logic signed [SPEED_W-1:0] s_max;
    logic signed [TEMP_W-1:0]  t_lo;
    logic signed [SPEED_W-1:0] s_lo;
    logic signed [TEMP_W-1:0]  t_hi;
    logic signed [SPEED_W-1:0] s_hi;
  } scan_res_t;

  function automatic logic [PCT_W-1:0] clamp_pct(input logic signed [SPEED_W-1:0] s);
    logic [PCT_W-1:0] r;
    if (s < 0) begin
      r = MIN_PCT;
    end else if (s > $signed({1'b0, MAX_PCT})) begin
      r = MAX_PCT;
    end else begin
      r = s[PCT_W-1:0];
    end
    return r;
  endfunction

endpackage

[design/fci_scan.sv]
module fci_scan
  import fci_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  logic                      first,
  input  logic signed [TEMP_W-1:0]  pt_temp,
  input  logic signed [SPEED_W-1:0] pt_speed,
  input  logic signed [TEMP_W-1:0]  temp,
  output scan_res_t                 res
);

  scan_res_t res_r, res_nxt;
  logic      lo_v_r, lo_v_nxt;
  logic      hi_v_r, hi_v_nxt;
  logic      below;

  always_comb begin
    res_nxt  = res_r;
    lo_v_nxt = lo_v_r;
    hi_v_nxt = hi_v_r;
    below    = pt_temp < temp;
    if (first) begin
      res_nxt.t_min = pt_temp;
      res_nxt.s_min = pt_speed;
      res_nxt.t_max = pt_temp;
      res_nxt.s_max = pt_speed;
      lo_v_nxt      = below;
      hi_v_nxt      = !below;
      res_nxt.t_lo  = pt_temp;
      res_nxt.s_lo  = pt_speed;
      res_nxt.t_hi  = pt_temp;
      res_nxt.s_hi  = pt_speed;
    end else begin
      if (pt_temp < res_r.t_min) begin
        res_nxt.t_min = pt_temp;
        res_nxt.s_min = pt_speed;
      end else if (pt_temp == res_r.t_min && pt_speed > res_r.s_min) begin
        res_nxt.s_min = pt_speed;
      end
      if (pt_temp > res_r.t_max) begin
        res_nxt.t_max = pt_temp;
        res_nxt.s_max = pt_speed;
      end else if (pt_temp == res_r.t_max && pt_speed > res_r.s_max) begin
        res_nxt.s_max = pt_speed;
      end
      if (below) begin
        if (!lo_v_r || pt_temp > res_r.t_lo) begin
          lo_v_nxt     = 1'b1;
          res_nxt.t_lo = pt_temp;
          res_nxt.s_lo = pt_speed;
        end else if (pt_temp == res_r.t_lo && pt_speed > res_r.s_lo) begin
          res_nxt.s_lo = pt_speed;
        end
      end else begin
        if (!hi_v_r || pt_temp < res_r.t_hi) begin
          hi_v_nxt     = 1'b1;
          res_nxt.t_hi = pt_temp;
          res_nxt.s_hi = pt_speed;
        end else if (pt_temp == res_r.t_hi && pt_speed > res_r.s_hi) begin
          res_nxt.s_hi = pt_speed;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lo_v_r <= 1'b0;
      hi_v_r <= 1'b0;
    end else if (en) begin
      lo_v_r <= lo_v_nxt;
      hi_v_r <= hi_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_r <= res_nxt;
    end
  end

  assign res = res_r;

endmodule

[design/fci_div.sv]
module fci_div
  import fci_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             done,
  output logic [DVD_W-1:0] quotient
);

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic [DVS_W-1:0] rem_r, rem_nxt;
  logic [DVD_W-1:0] quo_r, quo_nxt;
  logic [DVS_W-1:0] dvs_r, dvs_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             done_r, done_nxt;
  logic [DVS_W:0]   shifted;
  logic             ge;

  always_comb begin
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    shifted  = {rem_r, quo_r[DVD_W-1]};
    ge       = shifted >= {1'b0, dvs_r};
    if (start) begin
      rem_nxt = '0;
      quo_nxt = dividend;
      dvs_nxt = divisor;
      cnt_nxt = CNT_W'(DVD_W);
    end else if (cnt_r != '0) begin
      rem_nxt  = ge ? DVS_W'(shifted - {1'b0, dvs_r}) : DVS_W'(shifted);
      quo_nxt  = {quo_r[DVD_W-2:0], ge};
      cnt_nxt  = cnt_r - CNT_W'(1);
      done_nxt = cnt_r == CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

[design/fan_curve_interpolator_unit.sv]
// Sequence: n = min(point_count, MAX_POINTS). With no points the result strobes the cycle
// after acceptance; otherwise the scan steps through n points, then the result strobes out
// of the decide step when the sample lies at or beyond an end point; when it interpolates,
// a multiply step, a sum step and the shift-subtract divider follow. Throughput: one item
// at a time; busy drops in the cycle the result strobes, so a new item every cycle with no points.
// The receiver cannot stall: out_valid is high for one cycle per item.
// Reset (rst_n low, synchronous) clears all curve registers, the sequencer and the strobe.
module fan_curve_interpolator_unit
  import fci_pkg::*;
#(
  parameter int MAX_POINTS = MAX_POINTS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic signed [TEMP_W-1:0] in_temperature,
  output logic                     out_valid,
  output logic [PCT_W-1:0]         out_fan_percent,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CFG_DATA_W-1:0]    cfg_wdata
);

  localparam int IDX_W = $clog2(MAX_POINTS);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SCAN   = 3'd1;
  localparam logic [2:0] S_DECIDE = 3'd2;
  localparam logic [2:0] S_MUL    = 3'd3;
  localparam logic [2:0] S_SUM    = 3'd4;
  localparam logic [2:0] S_DIV    = 3'd5;

  logic [COUNT_W-1:0]    count_r;
  logic [CFG_DATA_W-1:0] pair_r [PAIRS];

  logic [2:0]              state_r, state_nxt;
  logic [IDX_W-1:0]        idx_r, idx_nxt;
  logic signed [TEMP_W-1:0] temp_r, temp_nxt;
  logic signed [DIFF_W-1:0] dt_r, dt_nxt;
  logic signed [DIFF_W-1:0] dtemp_r, dtemp_nxt;
  logic signed [DIFF_W-1:0] dspd_r, dspd_nxt;
  logic signed [SPEED_W-1:0] slo_r, slo_nxt;
  logic signed [P1_W-1:0]  p1_r, p1_nxt;
  logic signed [P2_W-1:0]  p2_r, p2_nxt;
  logic                    neg_r, neg_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic [PCT_W-1:0]        out_pct_r, out_pct_nxt;

  logic signed [TEMP_W-1:0]  pt_t [HW_POINTS];
  logic signed [SPEED_W-1:0] pt_s [HW_POINTS];
  logic [COUNT_W-1:0]        n_eff;
  logic [IDX_W-1:0]          idx_last;
  scan_res_t                 scan_res;
  logic signed [NUM_W-1:0]   num;
  logic [NUM_W-1:0]          mag;
  logic [DVD_W-1:0]          dividend;
  logic [DVS_W-1:0]          divisor;
  logic                      div_done;
  logic [DVD_W-1:0]          quotient;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      for (int k = 0; k < PAIRS; k++) begin
        pair_r[k] <= '0;
      end
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_POINT_COUNT: count_r   <= cfg_wdata[COUNT_W-1:0];
        CFG_POINTS_0_1:  pair_r[0] <= cfg_wdata;
        CFG_POINTS_2_3:  pair_r[1] <= cfg_wdata;
        CFG_POINTS_4_5:  pair_r[2] <= cfg_wdata;
        CFG_POINTS_6_7:  pair_r[3] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int k = 0; k < HW_POINTS; k++) begin
      pt_t[k] = pair_r[k/2][(k%2)*16 +: TEMP_W];
      pt_s[k] = pair_r[k/2][(k%2)*16 + 8 +: SPEED_W];
    end
  end

  assign n_eff    = (count_r > COUNT_W'(MAX_POINTS)) ? COUNT_W'(MAX_POINTS) : count_r;
  assign idx_last = IDX_W'(n_eff - COUNT_W'(1));

  fci_scan u_scan (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (state_r == S_SCAN),
    .first    (idx_r == '0),
    .pt_temp  (pt_t[PT_IDX_W'(idx_r)]),
    .pt_speed (pt_s[PT_IDX_W'(idx_r)]),
    .temp     (temp_r),
    .res      (scan_res)
  );

  assign num      = {{(NUM_W-P1_W){p1_r[P1_W-1]}}, p1_r}
                  + {{(NUM_W-P2_W){p2_r[P2_W-1]}}, p2_r};
  assign mag      = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
  assign dividend = DVD_W'({mag[NUM_W-2:0], 1'b0}) + DVD_W'(dt_r[TEMP_W-1:0]);
  assign divisor  = {dt_r[TEMP_W-1:0], 1'b0};

  fci_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (state_r == S_SUM),
    .dividend (dividend),
    .divisor  (divisor),
    .done     (div_done),
    .quotient (quotient)
  );

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    temp_nxt      = temp_r;
    dt_nxt        = dt_r;
    dtemp_nxt     = dtemp_r;
    dspd_nxt      = dspd_r;
    slo_nxt       = slo_r;
    p1_nxt        = p1_r;
    p2_nxt        = p2_r;
    neg_nxt       = neg_r;
    out_valid_nxt = 1'b0;
    out_pct_nxt   = out_pct_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          temp_nxt = in_temperature;
          idx_nxt  = '0;
          if (n_eff == '0) begin
            out_valid_nxt = 1'b1;
            out_pct_nxt   = DEFAULT_PCT;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (idx_r == idx_last) begin
          state_nxt = S_DECIDE;
        end else begin
          idx_nxt = idx_r + IDX_W'(1);
        end
      end
      S_DECIDE: begin
        dt_nxt    = DIFF_W'(scan_res.t_hi) - DIFF_W'(scan_res.t_lo);
        dtemp_nxt = DIFF_W'(temp_r) - DIFF_W'(scan_res.t_lo);
        dspd_nxt  = DIFF_W'(scan_res.s_hi) - DIFF_W'(scan_res.s_lo);
        slo_nxt   = scan_res.s_lo;
        if (temp_r <= scan_res.t_min) begin
          out_valid_nxt = 1'b1;
          out_pct_nxt   = clamp_pct(scan_res.s_min);
          state_nxt     = S_IDLE;
        end else if (temp_r >= scan_res.t_max) begin
          out_valid_nxt = 1'b1;
          out_pct_nxt   = clamp_pct(scan_res.s_max);
          state_nxt     = S_IDLE;
        end else begin
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        p1_nxt    = P1_W'(slo_r) * P1_W'(dt_r);
        p2_nxt    = P2_W'(dtemp_r) * P2_W'(dspd_r);
        state_nxt = S_SUM;
      end
      S_SUM: begin
        neg_nxt   = num[NUM_W-1];
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (div_done) begin
          out_valid_nxt = 1'b1;
          if (neg_r) begin
            out_pct_nxt = MIN_PCT;
          end else if (quotient > DVD_W'(MAX_PCT)) begin
            out_pct_nxt = MAX_PCT;
          end else begin
            out_pct_nxt = quotient[PCT_W-1:0];
          end
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    temp_r    <= temp_nxt;
    dt_r      <= dt_nxt;
    dtemp_r   <= dtemp_nxt;
    dspd_r    <= dspd_nxt;
    slo_r     <= slo_nxt;
    p1_r      <= p1_nxt;
    p2_r      <= p2_nxt;
    neg_r     <= neg_nxt;
    out_pct_r <= out_pct_nxt;
  end

  assign busy            = state_r != S_IDLE;
  assign out_valid       = out_valid_r;
  assign out_fan_percent = out_pct_r;

`ifndef SYNTHESIS
  a_pct_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_fan_percent <= MAX_PCT)
    else $error("fan percent above limit");

  a_done_strobes: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_valid)
    else $error("item finished without a result");

  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && n_eff != '0) |=> busy && !out_valid)
    else $error("item with points did not enter the scan");

  a_div_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == S_DIV)
    else $error("divider finished outside the divide phase");
`endif

endmodule
